// ----- src/hvt_pkg.sv -----
// Shared types, constants and width helpers for the homogeneous vertex transform unit.
// Used by every module of the block except hvt_skid; depends on nothing.
package hvt_pkg;

    localparam int MAT_DIM     = 4;
    localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;
    localparam int LANES       = 3;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_POINT = 2'd1,
        OP_DIR   = 2'd2
    } hvt_op_t;

    typedef struct packed {
        logic valid;
        logic point;
        logic wzero;
    } hvt_ctl_t;

    // Width of an exact row sum of three products and the scaled w column term.
    function automatic int sum_w(input int cw, input int fb);
        return ((2 * cw > cw + fb) ? 2 * cw : cw + fb) + 2;
    endfunction

    // Magnitude width: must also hold 1.0 at the doubled fraction scale.
    function automatic int mag_w(input int cw, input int fb);
        return (sum_w(cw, fb) > 2 * fb + 1) ? sum_w(cw, fb) : 2 * fb + 1;
    endfunction

    function automatic int quo_w(input int cw);
        return cw + 1;
    endfunction

    function automatic int num_w(input int cw, input int fb);
        return mag_w(cw, fb) + fb + 2;
    endfunction

    function automatic int den_w(input int cw, input int fb);
        return mag_w(cw, fb) + 1;
    endfunction

endpackage

// ----- src/hvt_mac.sv -----
// Matrix-vector multiply stages: twelve products, then the four exact row sums.
// Depends on hvt_pkg.
module hvt_mac #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  hvt_pkg::hvt_ctl_t         ctl_in,
    input  logic signed [CW-1:0]      coord [hvt_pkg::LANES],
    input  logic signed [CW-1:0]      mat [hvt_pkg::MAT_ENTRIES],
    output hvt_pkg::hvt_ctl_t         ctl_out,
    output logic signed [hvt_pkg::sum_w(CW, FB)-1:0] sum [hvt_pkg::MAT_DIM]
);
    import hvt_pkg::*;

    localparam int SW = sum_w(CW, FB);

    logic signed [2*CW-1:0] prod_reg [MAT_DIM][LANES];
    logic signed [CW-1:0]   wcol_reg [MAT_DIM];
    logic signed [SW-1:0]   sum_reg  [MAT_DIM];
    hvt_ctl_t               ctl_a_reg;
    hvt_ctl_t               ctl_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    for (genvar r = 0; r < MAT_DIM; r++)
    begin : g_row
        for (genvar c = 0; c < LANES; c++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[r][c] <= mat[r*MAT_DIM+c] * coord[c];
                end
            end
        end

        // The fourth vector element is 1.0 for a point and 0.0 for a direction.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                wcol_reg[r] <= ctl_in.point ? mat[r*MAT_DIM+MAT_DIM-1] : '0;
                sum_reg[r]  <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                             + SW'(prod_reg[r][2]) + (SW'(wcol_reg[r]) <<< FB);
            end
        end

        assign sum[r] = sum_reg[r];
    end

    assign ctl_out = ctl_b_reg;

endmodule

// ----- src/hvt_prep.sv -----
// Divider setup: magnitudes and signs of the row sums, divisor choice and numerators.
// Depends on hvt_pkg.
module hvt_prep #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  hvt_pkg::hvt_ctl_t        ctl_in,
    input  logic signed [hvt_pkg::sum_w(CW, FB)-1:0] sum [hvt_pkg::MAT_DIM],
    output hvt_pkg::hvt_ctl_t        ctl_out,
    output logic [hvt_pkg::den_w(CW, FB)-1:0] rem [hvt_pkg::LANES],
    output logic [hvt_pkg::quo_w(CW)-1:0]     low [hvt_pkg::LANES],
    output logic [hvt_pkg::den_w(CW, FB)-1:0] den2,
    output logic                     ovf [hvt_pkg::LANES],
    output logic                     neg [hvt_pkg::LANES]
);
    import hvt_pkg::*;

    localparam int SW = sum_w(CW, FB);
    localparam int MW = mag_w(CW, FB);
    localparam int QW = quo_w(CW);
    localparam int NW = num_w(CW, FB);
    localparam int DW = den_w(CW, FB);
    localparam int HW = NW - QW;
    localparam int LW = (HW > DW) ? HW : DW;

    logic [SW-1:0] abs_s [MAT_DIM];
    logic          wz_c;
    logic [MW-1:0] den_c;

    logic [MW-1:0] mag_reg [LANES];
    logic          negn_reg [LANES];
    logic [MW-1:0] den_reg;
    logic          negd_reg;
    hvt_ctl_t      ctl_c_reg;
    hvt_ctl_t      ctl_d_reg;

    logic [DW-1:0] rem_reg [LANES];
    logic [QW-1:0] low_reg [LANES];
    logic [DW-1:0] den2_reg;
    logic          ovf_reg [LANES];
    logic          neg_reg [LANES];

    for (genvar r = 0; r < MAT_DIM; r++)
    begin : g_abs
        assign abs_s[r] = sum[r][SW-1] ? SW'(-sum[r]) : SW'(sum[r]);
    end

    // A direction divides by 1.0 at the product scale, which gives plain rounding.
    // A zero w is replaced by one so the lanes stay defined; the result is masked.
    assign wz_c  = ctl_in.point && (sum[MAT_DIM-1] == '0);
    assign den_c = wz_c         ? MW'(1)
                 : ctl_in.point ? MW'(abs_s[MAT_DIM-1])
                 : (MW'(1) << (2 * FB));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end
        else if (en)
        begin
            ctl_c_reg <= '{valid: ctl_in.valid, point: ctl_in.point, wzero: wz_c};
            ctl_d_reg <= ctl_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_c;
            negd_reg <= ctl_in.point && sum[MAT_DIM-1][SW-1];
            den2_reg <= {den_reg, 1'b0};
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [NW-1:0] num;
        logic [HW-1:0] hi;

        // Numerator is |s| * 2^(FB+1) + |d| over 2|d|: round half away from zero.
        assign num = (NW'(mag_reg[i]) << (FB + 1)) + NW'(den_reg);
        assign hi  = num[NW-1:QW];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[i]  <= MW'(abs_s[i]);
                negn_reg[i] <= sum[i][SW-1];
                rem_reg[i]  <= DW'(hi);
                low_reg[i]  <= num[QW-1:0];
                ovf_reg[i]  <= (LW'(hi) >= LW'({den_reg, 1'b0}));
                neg_reg[i]  <= negn_reg[i] ^ negd_reg;
            end
        end

        assign rem[i] = rem_reg[i];
        assign low[i] = low_reg[i];
        assign ovf[i] = ovf_reg[i];
        assign neg[i] = neg_reg[i];
    end

    assign den2    = den2_reg;
    assign ctl_out = ctl_d_reg;

endmodule

// ----- src/hvt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage for three lanes,
// followed by the saturating sign stage. Depends on hvt_pkg.
module hvt_div #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  hvt_pkg::hvt_ctl_t        ctl_in,
    input  logic [hvt_pkg::den_w(CW, FB)-1:0] rem_in [hvt_pkg::LANES],
    input  logic [hvt_pkg::quo_w(CW)-1:0]     low_in [hvt_pkg::LANES],
    input  logic [hvt_pkg::den_w(CW, FB)-1:0] den2_in,
    input  logic                     ovf_in [hvt_pkg::LANES],
    input  logic                     neg_in [hvt_pkg::LANES],
    output hvt_pkg::hvt_ctl_t        ctl_out,
    output logic signed [CW-1:0]     word [hvt_pkg::LANES],
    output logic                     sat
);
    import hvt_pkg::*;

    localparam int QW = quo_w(CW);
    localparam int DW = den_w(CW, FB);

    logic [DW-1:0] rem_p [QW+1][LANES];
    logic [QW-1:0] low_p [QW+1][LANES];
    logic [QW-1:0] quo_p [QW+1][LANES];
    logic          ovf_p [QW+1][LANES];
    logic          neg_p [QW+1][LANES];
    logic [DW-1:0] den_p [QW+1];
    hvt_ctl_t      ctl_p [QW+1];

    logic [CW-1:0] word_c [LANES];
    logic [LANES-1:0] clip_c;

    logic [CW-1:0] word_reg [LANES];
    logic          sat_reg;
    hvt_ctl_t      ctl_f_reg;

    assign den_p[0] = den2_in;
    assign ctl_p[0] = ctl_in;

    for (genvar i = 0; i < LANES; i++)
    begin : g_in
        assign rem_p[0][i] = rem_in[i];
        assign low_p[0][i] = low_in[i];
        assign quo_p[0][i] = '0;
        assign ovf_p[0][i] = ovf_in[i];
        assign neg_p[0][i] = neg_in[i];
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_p[k+1] <= '0;
            end
            else if (en)
            begin
                ctl_p[k+1] <= ctl_p[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_p[k+1] <= den_p[k];
            end
        end

        for (genvar i = 0; i < LANES; i++)
        begin : g_lane
            logic [DW:0] trial;
            logic        take;

            assign trial = {rem_p[k][i], low_p[k][i][QW-1]};
            assign take  = (trial >= {1'b0, den_p[k]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_p[k+1][i] <= take ? DW'(trial - {1'b0, den_p[k]}) : DW'(trial);
                    low_p[k+1][i] <= {low_p[k][i][QW-2:0], 1'b0};
                    quo_p[k+1][i] <= {quo_p[k][i][QW-2:0], take};
                    ovf_p[k+1][i] <= ovf_p[k][i];
                    neg_p[k+1][i] <= neg_p[k][i];
                end
            end
        end
    end

    // Clamp to the signed range; the negative bound is one step further out.
    for (genvar i = 0; i < LANES; i++)
    begin : g_fin
        logic [QW-1:0] limit;
        logic [QW-1:0] mag;

        assign limit     = neg_p[QW][i] ? (QW'(1) << (CW - 1))
                                        : ((QW'(1) << (CW - 1)) - QW'(1));
        assign clip_c[i] = ovf_p[QW][i] || (quo_p[QW][i] > limit);
        assign mag       = clip_c[i] ? limit : quo_p[QW][i];
        assign word_c[i] = neg_p[QW][i] ? CW'(-mag) : CW'(mag);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                word_reg[i] <= ctl_p[QW].wzero ? '0 : word_c[i];
            end
        end

        assign word[i] = word_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_f_reg <= '0;
        end
        else if (en)
        begin
            ctl_f_reg <= ctl_p[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= (|clip_c) && !ctl_p[QW].wzero;
        end
    end

    assign sat     = sat_reg;
    assign ctl_out = ctl_f_reg;

endmodule

// ----- src/hvt_skid.sv -----
// Output register with one skid entry; its fill state freezes the pipeline.
// Does not depend on hvt_pkg.
module hvt_skid #(
    parameter int W = 98
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         en,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] skid_data_reg;
    logic         produce;
    logic         load_out;
    logic         load_skid;

    assign en      = !skid_valid_reg;
    assign produce = in_valid && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                load_out       = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
                load_skid       = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= in_data;
        end
        else if (skid_valid_reg && out_ready)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("word produced during stall was not kept");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry did not move to the output register");

endmodule

// ----- src/homogeneous_vertex_transform_unit.sv -----
// Homogeneous 4x4 vertex transform with perspective divide, signed fixed point.
// Top level; instantiates hvt_mac, hvt_prep, hvt_div and hvt_skid; uses hvt_pkg.
//
// Usage: input words arrive on the s_axis channel, tuser carries the opcode.
// A load word writes one entry of the stored matrix and produces no output.
// A point word (w = 1.0) is multiplied by the matrix and divided by the
// resulting w; a direction word (w = 0.0) is multiplied and rounded only.
// Opcode 3 is dropped. Each transform yields one m_axis word with the three
// coordinates in tdata and the zero-w and saturation flags in tuser.
// Throughput is one word per clock while no stall freezes the pipeline; the
// long part of the pipeline is the divider, which resolves one quotient bit
// per stage for three lanes.
// A load takes effect for every transform word accepted after it.
// Reset clears all valid bits and sets the matrix to identity.
// When the receiver stalls, a finished word waits in the output register and
// one more lands in a skid entry; only then does the pipeline freeze and
// s_axis_tready drop. Nothing is lost or repeated across a stall.
module homogeneous_vertex_transform_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: entry_row[1:0], entry_col[3:2], entry_value, coord_x, coord_y, coord_z
    input  logic [((4 + 4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [hvt_pkg::OP_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: out_x, out_y, out_z, zero filled to whole bytes
    output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: w_zero[0], saturated[1]
    output logic [1:0] m_axis_tuser
);
    import hvt_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
    localparam int PAY_W = LANES * CW + 2;
    localparam int IDX_W = $clog2(MAT_ENTRIES);
    localparam int SW    = sum_w(CW, FB);
    localparam int QW    = quo_w(CW);
    localparam int DW    = den_w(CW, FB);

    logic                 en;

    // Input register stage.
    logic                 s1_valid_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic signed [CW-1:0] s1_value_reg;
    logic signed [CW-1:0] s1_coord_reg [LANES];

    logic signed [CW-1:0] mat_reg [MAT_ENTRIES];
    logic                 mat_we;
    hvt_ctl_t             mac_ctl_in;

    hvt_ctl_t             mac_ctl;
    logic signed [SW-1:0] mac_sum [MAT_DIM];
    hvt_ctl_t             prep_ctl;
    logic [DW-1:0]        prep_rem [LANES];
    logic [QW-1:0]        prep_low [LANES];
    logic [DW-1:0]        prep_den2;
    logic                 prep_ovf [LANES];
    logic                 prep_neg [LANES];
    hvt_ctl_t             div_ctl;
    logic signed [CW-1:0] div_word [LANES];
    logic                 div_sat;
    logic [PAY_W-1:0]     pay_in;
    logic [PAY_W-1:0]     pay_out;

    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    // The matrix index is row * 4 + column; the row sits in the lowest bits of tdata.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg    <= s_axis_tuser;
            s1_idx_reg   <= {s_axis_tdata[1:0], s_axis_tdata[3:2]};
            s1_value_reg <= s_axis_tdata[IDX_W +: CW];
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_coord
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_coord_reg[i] <= s_axis_tdata[IDX_W + CW * (i + 1) +: CW];
            end
        end
    end

    // Decode the opcode of the word in the input stage.
    always_comb
    begin
        mac_ctl_in = '0;
        mat_we     = 1'b0;
        unique case (s1_op_reg)
            OP_LOAD:
            begin
                mat_we = s1_valid_reg;
            end
            OP_POINT:
            begin
                mac_ctl_in.valid = s1_valid_reg;
                mac_ctl_in.point = 1'b1;
            end
            OP_DIR:
            begin
                mac_ctl_in.valid = s1_valid_reg;
            end
            default:
            begin
                mac_ctl_in = '0;
            end
        endcase
    end

    // The matrix is written as the load word leaves the input stage, so every
    // transform ahead of it has already taken its products.
    for (genvar e = 0; e < MAT_ENTRIES; e++)
    begin : g_mat
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mat_reg[e] <= ((e % (MAT_DIM + 1)) == 0) ? (CW'(1) << FB) : '0;
            end
            else if (en && mat_we && (s1_idx_reg == IDX_W'(e)))
            begin
                mat_reg[e] <= s1_value_reg;
            end
        end
    end

    hvt_mac #(.CW(CW), .FB(FB)) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (mac_ctl_in),
        .coord   (s1_coord_reg),
        .mat     (mat_reg),
        .ctl_out (mac_ctl),
        .sum     (mac_sum)
    );

    hvt_prep #(.CW(CW), .FB(FB)) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (mac_ctl),
        .sum     (mac_sum),
        .ctl_out (prep_ctl),
        .rem     (prep_rem),
        .low     (prep_low),
        .den2    (prep_den2),
        .ovf     (prep_ovf),
        .neg     (prep_neg)
    );

    hvt_div #(.CW(CW), .FB(FB)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (prep_ctl),
        .rem_in  (prep_rem),
        .low_in  (prep_low),
        .den2_in (prep_den2),
        .ovf_in  (prep_ovf),
        .neg_in  (prep_neg),
        .ctl_out (div_ctl),
        .word    (div_word),
        .sat     (div_sat)
    );

    assign pay_in = {div_sat, div_ctl.wzero, div_word[2], div_word[1], div_word[0]};

    hvt_skid #(.W(PAY_W)) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_ctl.valid),
        .in_data   (pay_in),
        .en        (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (pay_out)
    );

    assign m_axis_tdata = OUT_W'(pay_out[LANES*CW-1:0]);
    assign m_axis_tuser = pay_out[PAY_W-1:LANES*CW];

endmodule
